>>> hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("motion cue check failed");

// Clocked property, checked during reset too.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("motion cue check failed");

`endif

>>> hdl/mcg_pkg.sv
package mcg_pkg;

   // shared multiplier operand and product widths
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 24;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // angle units: 1/128 degree
   localparam int FULL_TURN = 46080;
   localparam int HALF_TURN = 23040;

   // register indexes
   localparam logic [2:0] CSR_GAIN_SS     = 3'd0;
   localparam logic [2:0] CSR_GAIN_HY     = 3'd1;
   localparam logic [2:0] CSR_FORCE_ROLL  = 3'd2;
   localparam logic [2:0] CSR_FORCE_PITCH = 3'd3;
   localparam logic [2:0] CSR_FORCE_YAW   = 3'd4;
   localparam logic [2:0] CSR_FORCE_HEAVE = 3'd5;
   localparam logic [2:0] CSR_FORCE_SWAY  = 3'd6;
   localparam logic [2:0] CSR_FORCE_SURGE = 3'd7;

   // input kinds carried on tuser
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // operands of the shared multiplier
   typedef struct packed {
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
   } mul_op_type;

   // reduce an angle sum into (-180, +180]; one correction covers the input range
   function automatic logic signed [15:0] wrap_angle(input logic signed [17:0] s);
      logic signed [17:0] r;
      r = s;
      if (s > 18'sd23040) begin
         r = s - 18'sd46080;
      end else if (s <= -18'sd23040) begin
         r = s + 18'sd46080;
      end
      return r[15:0];
   endfunction

   // clamp to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
      logic signed [31:0] r;
      r = v[31:0];
      if (v > 49'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -49'sd2147483648) begin
         r = 32'sh80000000;
      end
      return r;
   endfunction

endpackage

>>> hdl/mcg_mul.sv
// Shared signed multiplier with registered product.
module mcg_mul (
   input  logic                                clock,
   input  mcg_pkg::mul_op_type                 op,
   output logic signed [mcg_pkg::MUL_P_W-1:0]  prod
);
   import mcg_pkg::*;

   logic signed [MUL_P_W-1:0] prod_ff;
   logic signed [MUL_P_W-1:0] prod_in;

   assign prod_in = MUL_P_W'(op.a) * MUL_P_W'(op.b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

>>> hdl/motion_cue_generator.sv
// Motion cue generator. A start beat (tuser 0) loads the pose and gives no
// result; ready stays high. A tick beat (tuser 1) steps through a schedule on one
// shared 33x24 multiplier (gain scaling, three 3-term dot products, gain products
// split in two halves, yaw scaling), then holds the six cues on rsp until taken.
// Config writes are expected only while idle.
module motion_cue_generator #(
   parameter int POSITION_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   // pos_x, pos_y, pos_z, forward_axis, right_axis, up_axis, yaw, roll, pitch
   input  logic [287:0] req_tdata,
   input  logic         req_tuser,   // cmd
   input  logic         req_tvalid,
   output logic         req_tready,
   // out_roll, out_pitch, out_yaw, out_heave, out_sway, out_surge
   output logic [191:0] rsp_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);
   import mcg_pkg::*;

   localparam int PW = POSITION_WIDTH;
   localparam logic [4:0] LAST_STEP = 5'd21;

   typedef enum logic [1:0] {S_IDLE, S_CALC, S_SEND} state_type;

   state_type state_ff;
   logic [4:0] step_ff;

   // config
   logic [31:0]        gain_ss_ff, gain_hy_ff;
   logic signed [31:0] force_ff [6];

   // state
   logic signed [PW-1:0] last_pos_ff [3];
   logic signed [PW:0]   last_vel_ff [3];
   logic signed [15:0]   neg_yaw_ff;
   logic signed [31:0]   acc_ff [4];

   // captured beat
   logic signed [PW-1:0] pos_ff [3];
   logic [47:0]          axis_ff [3];
   logic signed [15:0]   yaw_ff, roll_ff, pitch_ff;

   // working registers
   logic signed [31:0] dv_ff [3];
   logic signed [18:0] d5_ff;
   logic signed [22:0] g100_ff [3];
   logic signed [49:0] proj_ff [3];
   logic signed [73:0] big_ff;
   logic signed [34:0] yawp_ff;
   logic [191:0]       rsp_data_ff;

   logic signed [15:0] gain [4];
   mul_op_type         mop;
   logic signed [MUL_P_W-1:0] prod;

   assign gain[0] = gain_ss_ff[15:0];
   assign gain[1] = gain_ss_ff[31:16];
   assign gain[2] = gain_hy_ff[15:0];
   assign gain[3] = gain_hy_ff[31:16];

   mcg_mul u_mul (.clock(clock), .op(mop), .prod(prod));

   // multiplier operand schedule
   always_comb begin
      mop = '0;
      unique case (step_ff)
         5'd0, 5'd1, 5'd2: begin
            mop.a = MUL_A_W'(gain[step_ff[1:0]]);
            mop.b = 24'sd100;
         end
         5'd3, 5'd4, 5'd5: begin
            mop.a = MUL_A_W'(dv_ff[2'(step_ff - 5'd3)]);
            mop.b = MUL_B_W'($signed(axis_ff[0][16*(step_ff-5'd3) +: 16]));
         end
         5'd6, 5'd7, 5'd8: begin
            mop.a = MUL_A_W'(dv_ff[2'(step_ff - 5'd6)]);
            mop.b = MUL_B_W'($signed(axis_ff[1][16*(step_ff-5'd6) +: 16]));
         end
         5'd9, 5'd10, 5'd11: begin
            mop.a = MUL_A_W'(dv_ff[2'(step_ff - 5'd9)]);
            mop.b = MUL_B_W'($signed(axis_ff[2][16*(step_ff-5'd9) +: 16]));
         end
         5'd12, 5'd14, 5'd16: begin
            mop.a = $signed({8'b0, proj_ff[2'((step_ff - 5'd12) >> 1)][24:0]});
            mop.b = MUL_B_W'(g100_ff[2'((step_ff - 5'd12) >> 1)]);
         end
         5'd13, 5'd15, 5'd17: begin
            mop.a = MUL_A_W'($signed(proj_ff[2'((step_ff - 5'd13) >> 1)][49:25]));
            mop.b = MUL_B_W'(g100_ff[2'((step_ff - 5'd13) >> 1)]);
         end
         5'd18: begin
            mop.a = MUL_A_W'(d5_ff);
            mop.b = MUL_B_W'(gain[3]);
         end
         default: mop = '0;
      endcase
   end

   // position and velocity difference for step 0
   logic signed [PW:0]   vel [3];
   logic signed [PW+1:0] dv_full [3];
   logic signed [63:0]   dv_wide [3];
   logic signed [31:0]   dv_sat [3];
   logic signed [15:0]   yaw_d;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vel[i]     = (PW+1)'(pos_ff[i]) - (PW+1)'(last_pos_ff[i]);
         dv_full[i] = (PW+2)'(vel[i]) - (PW+2)'(last_vel_ff[i]);
         dv_wide[i] = 64'(dv_full[i]);
         if (dv_wide[i] > 64'sd2147483647) begin
            dv_sat[i] = 32'sh7FFFFFFF;
         end else if (dv_wide[i] < -64'sd2147483648) begin
            dv_sat[i] = 32'sh80000000;
         end else begin
            dv_sat[i] = dv_wide[i][31:0];
         end
      end
      yaw_d = wrap_angle(18'(neg_yaw_ff) + 18'(yaw_ff));
   end

   // hundredths from the full gain product, then accumulate
   logic signed [39:0] k_big;
   logic signed [73:0] big_rnd;
   logic signed [48:0] acc_sum_big;
   logic signed [16:0] k_yaw;
   logic signed [34:0] yaw_rnd;
   logic signed [48:0] acc_sum_yaw;
   logic [1:0]         acc_sel;
   always_comb begin
      big_rnd = big_ff + (big_ff[73] ? 74'sh3FFFFFFFF : 74'sd0);
      k_big   = 40'(big_rnd >>> 34);
      yaw_rnd = yawp_ff + (yawp_ff[34] ? 35'sh3FFFF : 35'sd0);
      k_yaw   = 17'(yaw_rnd >>> 18);
      acc_sel = (step_ff == 5'd15) ? 2'd0 : ((step_ff == 5'd17) ? 2'd1 : 2'd2);
      acc_sum_big = 49'(acc_ff[acc_sel]) + 49'($signed({k_big, 8'b0}));
      acc_sum_yaw = 49'(acc_ff[3]) + 49'($signed({k_yaw, 8'b0}));
   end

   // roll/pitch cues and output words
   logic signed [15:0] ang_w [2];
   logic signed [18:0] ang5 [2];
   logic signed [12:0] ang_q [2];
   logic signed [31:0] cue [6];
   logic [191:0]       rsp_data_in;
   always_comb begin
      ang_w[0] = wrap_angle(18'(roll_ff));
      ang_w[1] = wrap_angle(18'(pitch_ff));
      for (int i = 0; i < 2; i++) begin
         ang5[i]  = (19'(ang_w[i]) <<< 2) + 19'(ang_w[i]);
         ang_q[i] = 13'((ang5[i] + (ang5[i][18] ? 19'sd63 : 19'sd0)) >>> 6);
         cue[i]   = 32'($signed({ang_q[i], 8'b0}));
      end
      cue[2] = acc_ff[3];
      cue[3] = acc_ff[2];
      cue[4] = acc_ff[1];
      cue[5] = acc_ff[0];
      for (int i = 0; i < 6; i++) begin
         rsp_data_in[32*i +: 32] = sat32(49'(cue[i]) + 49'(force_ff[i]));
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_SEND);
   assign rsp_tdata  = rsp_data_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ss_ff <= 32'd268439552;
         gain_hy_ff <= 32'd268439552;
         for (int i = 0; i < 6; i++) force_ff[i] <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN_SS:     gain_ss_ff  <= csr_wdata;
            CSR_GAIN_HY:     gain_hy_ff  <= csr_wdata;
            CSR_FORCE_ROLL:  force_ff[0] <= csr_wdata;
            CSR_FORCE_PITCH: force_ff[1] <= csr_wdata;
            CSR_FORCE_YAW:   force_ff[2] <= csr_wdata;
            CSR_FORCE_HEAVE: force_ff[3] <= csr_wdata;
            CSR_FORCE_SWAY:  force_ff[4] <= csr_wdata;
            CSR_FORCE_SURGE: force_ff[5] <= csr_wdata;
            default:         gain_ss_ff  <= gain_ss_ff;
         endcase
      end
   end

   // payload capture and working registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         pos_ff[0]  <= PW'($signed(req_tdata[31:0]));
         pos_ff[1]  <= PW'($signed(req_tdata[63:32]));
         pos_ff[2]  <= PW'($signed(req_tdata[95:64]));
         axis_ff[0] <= req_tdata[143:96];
         axis_ff[1] <= req_tdata[191:144];
         axis_ff[2] <= req_tdata[239:192];
         yaw_ff     <= req_tdata[255:240];
         roll_ff    <= req_tdata[271:256];
         pitch_ff   <= req_tdata[287:272];
      end
      if (state_ff == S_CALC) begin
         unique case (step_ff)
            5'd0: begin
               for (int i = 0; i < 3; i++) dv_ff[i] <= dv_sat[i];
               d5_ff <= (19'(yaw_d) <<< 2) + 19'(yaw_d);
            end
            5'd1, 5'd2, 5'd3: g100_ff[2'(step_ff - 5'd1)] <= prod[22:0];
            5'd4: proj_ff[0] <= prod[49:0];
            5'd7: proj_ff[1] <= prod[49:0];
            5'd10: proj_ff[2] <= prod[49:0];
            5'd5, 5'd6: proj_ff[0] <= proj_ff[0] + prod[49:0];
            5'd8, 5'd9: proj_ff[1] <= proj_ff[1] + prod[49:0];
            5'd11, 5'd12: proj_ff[2] <= proj_ff[2] + prod[49:0];
            5'd13, 5'd15, 5'd17: big_ff <= 74'(prod);
            5'd14, 5'd16, 5'd18: big_ff <= big_ff + (74'(prod) <<< 25);
            5'd19: yawp_ff <= prod[34:0];
            5'd21: rsp_data_ff <= rsp_data_in;
            default: yawp_ff <= yawp_ff;
         endcase
      end
   end

   // sequencer and pose state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         step_ff    <= '0;
         neg_yaw_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            last_pos_ff[i] <= '0;
            last_vel_ff[i] <= '0;
         end
         for (int i = 0; i < 4; i++) acc_ff[i] <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               step_ff <= '0;
               if (req_tvalid) begin
                  if (req_tuser == CMD_START) begin
                     last_pos_ff[0] <= PW'($signed(req_tdata[31:0]));
                     last_pos_ff[1] <= PW'($signed(req_tdata[63:32]));
                     last_pos_ff[2] <= PW'($signed(req_tdata[95:64]));
                     for (int i = 0; i < 3; i++) last_vel_ff[i] <= '0;
                     for (int i = 0; i < 4; i++) acc_ff[i] <= '0;
                     neg_yaw_ff <= wrap_angle(-18'($signed(req_tdata[255:240])));
                  end else begin
                     state_ff <= S_CALC;
                  end
               end
            end
            S_CALC: begin
               step_ff <= step_ff + 5'd1;
               unique case (step_ff)
                  5'd0: begin
                     for (int i = 0; i < 3; i++) begin
                        last_pos_ff[i] <= pos_ff[i];
                        last_vel_ff[i] <= vel[i];
                     end
                     neg_yaw_ff <= wrap_angle(-18'(yaw_ff));
                  end
                  5'd15: acc_ff[0] <= sat32(acc_sum_big);
                  5'd17: acc_ff[1] <= sat32(acc_sum_big);
                  5'd19: acc_ff[2] <= sat32(acc_sum_big);
                  5'd20: acc_ff[3] <= sat32(acc_sum_yaw);
                  LAST_STEP: begin
                     // halve toward zero as the outputs are captured
                     for (int i = 0; i < 4; i++) begin
                        acc_ff[i] <= $signed(acc_ff[i] + 32'(acc_ff[i][31])) >>> 1;
                     end
                     state_ff <= S_SEND;
                  end
                  default: ;
               endcase
            end
            S_SEND: begin
               if (rsp_tready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

>>> hdl/mcg_checker.sv
// Port-level checks for the motion cue generator.
`include "assert_macros.svh"

module mcg_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic req_tuser,
   input logic rsp_tvalid,
   input logic rsp_tready
);

   // one item in flight: never taking a beat while a result waits
   `ASSERT_CLK(a_no_overlap, clock, reset, !(req_tready && rsp_tvalid))

   // a start beat gives no result and leaves the block ready
   `ASSERT_CLK(a_start_quiet, clock, reset, (req_tvalid && req_tready && !req_tuser) |=> (req_tready && !rsp_tvalid))

   // a tick beat takes the block busy
   `ASSERT_CLK(a_tick_busy, clock, reset, (req_tvalid && req_tready && req_tuser) |=> !req_tready)

   // a result beat holds until taken
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)

endmodule

bind motion_cue_generator mcg_checker u_mcg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
